### src/fttg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register codes for the frame time quality governor.
package fttg_pkg;

   // Tier range
   localparam int TIER_COUNT = 4;
   localparam int TIER_W     = 4;
   localparam logic [TIER_W-1:0] TIER_MAX = TIER_W'(TIER_COUNT - 1);

   // Field widths
   localparam int STAMP_W  = 32;
   localparam int LEVEL_W  = 16;
   localparam int TARGET_W = 20;
   localparam int FPU_W    = 8;
   localparam int TOL_W    = 16;
   localparam int MODE_W   = 3;
   localparam int GAIN_W   = 24;
   localparam int FRAC_W   = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET = 3'd0,
      CSR_FPU    = 3'd1,
      CSR_TOL    = 3'd2,
      CSR_MODE   = 3'd3,
      CSR_LMIN   = 3'd4,
      CSR_LMAX   = 3'd5,
      CSR_GAIN   = 3'd6
   } csr_idx_type;

   // Mode bit positions
   localparam int MODE_AUTO  = 0;
   localparam int MODE_LEVEL = 1;
   localparam int MODE_TIER  = 2;

   // Divider: one quotient bit per cycle
   localparam int DIV_STEPS = STAMP_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [FPU_W-1:0]    fpu;
      logic [TOL_W-1:0]    tol;
      logic [MODE_W-1:0]   mode;
      logic [LEVEL_W-1:0]  lmin;
      logic [LEVEL_W-1:0]  lmax;
      logic [GAIN_W-1:0]   gain;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic idle;
      logic accept;
      logic div_step;
      logic calc_err;
      logic calc_mul;
      logic calc_lvl;
      logic calc_tier;
      logic load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic upd_hit;
      logic rsp_busy;
   } sts_type;

endpackage

### src/fttg_csr.sv
`timescale 1ns / 1ps
// Configuration register bank of the frame time quality governor.
module fttg_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fttg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fttg_pkg::CSR_DATA_W-1:0]   csr_data,
   output fttg_pkg::cfg_type                 cfg
);

   fttg_pkg::cfg_type cfg_ff, cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (fttg_pkg::csr_idx_type'(csr_index))
            fttg_pkg::CSR_TARGET: cfg_in.target = csr_data[fttg_pkg::TARGET_W-1:0];
            fttg_pkg::CSR_FPU:    cfg_in.fpu    = csr_data[fttg_pkg::FPU_W-1:0];
            fttg_pkg::CSR_TOL:    cfg_in.tol    = csr_data[fttg_pkg::TOL_W-1:0];
            fttg_pkg::CSR_MODE:   cfg_in.mode   = csr_data[fttg_pkg::MODE_W-1:0];
            fttg_pkg::CSR_LMIN:   cfg_in.lmin   = csr_data[fttg_pkg::LEVEL_W-1:0];
            fttg_pkg::CSR_LMAX:   cfg_in.lmax   = csr_data[fttg_pkg::LEVEL_W-1:0];
            fttg_pkg::CSR_GAIN:   cfg_in.gain   = csr_data[fttg_pkg::GAIN_W-1:0];
            default:              cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target <= fttg_pkg::TARGET_W'(11111);
         cfg_ff.fpu    <= fttg_pkg::FPU_W'(1);
         cfg_ff.tol    <= '0;
         cfg_ff.mode   <= '0;
         cfg_ff.lmin   <= '0;
         cfg_ff.lmax   <= '1;
         cfg_ff.gain   <= fttg_pkg::GAIN_W'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/fttg_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing accept, divide, error, multiply and update.
module fttg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  fttg_pkg::sts_type   sts,
   output fttg_pkg::cmd_type   cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV  = 7'b0000010,
      ST_ERR  = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_LVL  = 7'b0010000,
      ST_TIER = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   localparam logic [fttg_pkg::DIV_CNT_W-1:0] DIV_LAST =
      fttg_pkg::DIV_CNT_W'(fttg_pkg::DIV_STEPS - 1);

   state_type                        state_ff, state_in;
   logic [fttg_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.idle   = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && sts.upd_hit) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.calc_err = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.calc_mul = 1'b1;
            state_in     = ST_LVL;
         end
         ST_LVL: begin
            cmd.calc_lvl = 1'b1;
            state_in     = ST_TIER;
         end
         ST_TIER: begin
            cmd.calc_tier = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!sts.rsp_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### src/fttg_dp.sv
`timescale 1ns / 1ps
// Datapath: frame counter, serial divider, error, gain multiply, clamp, tier, output register.
module fttg_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  fttg_pkg::cmd_type                   cmd,
   output fttg_pkg::sts_type                   sts,
   input  fttg_pkg::cfg_type                   cfg,
   input  logic [fttg_pkg::STAMP_W-1:0]        req_timestamp_us,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fttg_pkg::LEVEL_W-1:0]        rsp_quality_level,
   output logic [fttg_pkg::TIER_W-1:0]         rsp_tier_index,
   output logic [fttg_pkg::STAMP_W-1:0]        rsp_avg_period_us,
   output logic signed [fttg_pkg::STAMP_W-1:0] rsp_error_us
);

   localparam int SW   = fttg_pkg::STAMP_W;
   localparam int LW   = fttg_pkg::LEVEL_W;
   localparam int FW   = fttg_pkg::FPU_W;
   localparam int TW   = fttg_pkg::TIER_W;
   localparam int GW   = fttg_pkg::GAIN_W;
   localparam int FRW  = fttg_pkg::FRAC_W;
   localparam int DW   = SW + 2;              // error difference
   localparam int PW   = SW + GW + 1;         // signed product
   localparam int NW   = PW + 1;              // numerator
   localparam int QW   = NW - FRW;            // floored quotient

   localparam logic signed [DW-1:0] ERR_SAT = DW'(32'h7FFF_FFFF);

   // State
   logic [FW-1:0]            frame_count_ff, frame_count_in;
   logic [SW-1:0]            last_stamp_ff;
   logic [LW-1:0]            level_ff, level_in;
   logic [TW-1:0]            tier_ff, tier_in;
   logic [SW-1:0]            quo_ff, quo_in;
   logic [FW-1:0]            rem_ff, rem_in;
   logic signed [SW-1:0]     err_ff, err_in;
   logic signed [PW-1:0]     prod_ff;
   logic                     rsp_valid_ff;
   logic [LW-1:0]            rsp_level_ff;
   logic [TW-1:0]            rsp_tier_ff;
   logic [SW-1:0]            rsp_avg_ff;
   logic signed [SW-1:0]     rsp_err_ff;

   // Combinational helpers
   logic [FW-1:0]            cnt_next;
   logic                     upd_hit;
   logic [FW-1:0]            div_eff;
   logic [FW:0]              shifted;
   logic                     ge;
   logic signed [DW-1:0]     diff;
   logic signed [NW-1:0]     num;
   logic signed [QW-1:0]     q;
   logic                     auto_on;

   assign auto_on  = cfg.mode[fttg_pkg::MODE_AUTO];
   assign cnt_next = frame_count_ff + 1'b1;
   assign upd_hit  = !(cnt_next < cfg.fpu);
   assign div_eff  = (cfg.fpu == '0) ? FW'(1) : cfg.fpu;

   assign sts.upd_hit  = upd_hit;
   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;

   // Frame counter
   always_comb begin
      frame_count_in = frame_count_ff;
      if (cmd.accept) begin
         frame_count_in = upd_hit ? '0 : cnt_next;
      end
   end

   // Restoring divider, one quotient bit per step
   always_comb begin
      shifted = {rem_ff, quo_ff[SW-1]};
      ge      = shifted >= {1'b0, div_eff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (cmd.accept) begin
         quo_in = req_timestamp_us - last_stamp_ff;
         rem_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[SW-2:0], ge};
         rem_in = ge ? FW'(shifted - {1'b0, div_eff}) : shifted[FW-1:0];
      end
   end

   // Period error with saturation and dead zone
   always_comb begin
      diff   = $signed({2'b00, quo_ff}) - $signed({(DW - fttg_pkg::TARGET_W)'(0), cfg.target});
      err_in = err_ff;
      if (cmd.calc_err) begin
         if (!auto_on) begin
            err_in = '0;
         end else if (diff > ERR_SAT) begin
            err_in = ERR_SAT[SW-1:0];
         end else if (diff >= 0 && diff <= $signed({(DW - fttg_pkg::TOL_W)'(0), cfg.tol})) begin
            err_in = '0;
         end else begin
            err_in = diff[SW-1:0];
         end
      end
   end

   // Level step: floor((level*2^16 - err*gain) / 2^16), then clamp
   always_comb begin
      num      = $signed({(NW - LW - FRW)'(0), level_ff, FRW'(0)})
               - $signed({prod_ff[PW-1], prod_ff});
      q        = num[NW-1:FRW];
      level_in = level_ff;
      if (cmd.calc_lvl) begin
         if (auto_on && cfg.mode[fttg_pkg::MODE_LEVEL]) begin
            priority if (q < $signed({(QW - LW)'(0), cfg.lmin})) begin
               level_in = cfg.lmin;
            end else if (q > $signed({(QW - LW)'(0), cfg.lmax})) begin
               level_in = cfg.lmax;
            end else begin
               level_in = q[LW-1:0];
            end
         end else begin
            level_in = cfg.lmax;
         end
      end
   end

   // Tier stepping, up rule first, then down rule
   always_comb begin
      logic [TW-1:0] t;
      t       = tier_ff;
      tier_in = tier_ff;
      if (cmd.calc_tier && auto_on && cfg.mode[fttg_pkg::MODE_TIER]) begin
         if (level_ff <= cfg.lmin && err_ff > 0) begin
            t = (t >= fttg_pkg::TIER_MAX) ? fttg_pkg::TIER_MAX : t + 1'b1;
         end
         if (level_ff >= cfg.lmax && err_ff <= 0) begin
            t = (t == '0) ? '0 : t - 1'b1;
            if (t > fttg_pkg::TIER_MAX) begin
               t = fttg_pkg::TIER_MAX;
            end
         end
         tier_in = t;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         last_stamp_ff  <= '0;
         level_ff       <= '0;
         tier_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_count_ff <= frame_count_in;
         if (cmd.accept && upd_hit) begin
            last_stamp_ff <= req_timestamp_us;
         end
         level_ff <= level_in;
         tier_ff  <= tier_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      err_ff <= err_in;
      if (cmd.calc_mul) begin
         prod_ff <= PW'(err_ff) * PW'($signed({1'b0, cfg.gain}));
      end
      if (cmd.load_out) begin
         rsp_level_ff <= level_ff;
         rsp_tier_ff  <= tier_ff;
         rsp_avg_ff   <= quo_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_quality_level = rsp_level_ff;
   assign rsp_tier_index    = rsp_tier_ff;
   assign rsp_avg_period_us = rsp_avg_ff;
   assign rsp_error_us      = rsp_err_ff;

endmodule

### src/frame_time_quality_governor.sv
`timescale 1ns / 1ps
// Top level of the frame time quality governor.
//
// Each req beat is one frame event with a microsecond timestamp. A frame that
// does not close the averaging window is taken and gives no rsp beat. A frame
// that closes the window passes from accept through the bit-serial divider
// (one quotient bit per cycle) that forms the average period, then through the
// error, the gain multiply, the level clamp and the tier step to the output
// load. The load waits for as long as an earlier rsp beat is stalled. The next
// frame is accepted as soon as the result sits in the output register, even
// while rsp is stalled. Configuration writes are registered and csr_ready is
// always high.
module frame_time_quality_governor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fttg_pkg::STAMP_W-1:0]        req_timestamp_us,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fttg_pkg::LEVEL_W-1:0]        rsp_quality_level,
   output logic [fttg_pkg::TIER_W-1:0]         rsp_tier_index,
   output logic [fttg_pkg::STAMP_W-1:0]        rsp_avg_period_us,
   output logic signed [fttg_pkg::STAMP_W-1:0] rsp_error_us,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fttg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fttg_pkg::CSR_DATA_W-1:0]     csr_data
);

   fttg_pkg::cfg_type cfg;
   fttg_pkg::cmd_type cmd;
   fttg_pkg::sts_type sts;

   // Input side is open only while the controller idles
   assign req_stall = !cmd.idle;

   fttg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fttg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   fttg_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .cfg               (cfg),
      .req_timestamp_us  (req_timestamp_us),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_quality_level (rsp_quality_level),
      .rsp_tier_index    (rsp_tier_index),
      .rsp_avg_period_us (rsp_avg_period_us),
      .rsp_error_us      (rsp_error_us)
   );

endmodule

### src/fttg_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the frame time quality governor and its bind.
module fttg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [fttg_pkg::LEVEL_W-1:0]        rsp_quality_level,
   input logic [fttg_pkg::TIER_W-1:0]         rsp_tier_index,
   input logic [fttg_pkg::STAMP_W-1:0]        rsp_avg_period_us,
   input logic signed [fttg_pkg::STAMP_W-1:0] rsp_error_us
);

   // A stalled rsp beat stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // A stalled rsp beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_quality_level) && $stable(rsp_tier_index)
         && $stable(rsp_avg_period_us) && $stable(rsp_error_us))
      else $error("rsp payload changed while stalled");

   // Tier stays within the tier table
   a_tier_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tier_index <= fttg_pkg::TIER_MAX)
      else $error("tier index out of range");

   // A fresh rsp beat comes only out of a busy update
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("rsp beat without an update in progress");

endmodule

bind frame_time_quality_governor fttg_checker u_fttg_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_quality_level (rsp_quality_level),
   .rsp_tier_index    (rsp_tier_index),
   .rsp_avg_period_us (rsp_avg_period_us),
   .rsp_error_us      (rsp_error_us)
);

### bench/tb_frame_time_quality_governor.sv
`timescale 1ns / 1ps
// Self-checking bench for the frame time quality governor: frame beats in, update beats checked.
module tb_frame_time_quality_governor;

   localparam int ITEMS_TOTAL = 1890;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_LIMIT = 5000;
   localparam int TAIL_CYCLES = 50;
   localparam int PRINT_CAP   = 100;

   // One expected update beat
   typedef struct {
      logic [fttg_pkg::LEVEL_W-1:0]        level;
      logic [fttg_pkg::TIER_W-1:0]         tier;
      logic [fttg_pkg::STAMP_W-1:0]        avg;
      logic signed [fttg_pkg::STAMP_W-1:0] err;
   } gov_update_type;

   logic                                 clock;
   logic                                 reset            = 1'b1;
   logic                                 req_valid        = 1'b0;
   logic                                 req_stall;
   logic [fttg_pkg::STAMP_W-1:0]         req_timestamp_us = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall        = 1'b0;
   logic [fttg_pkg::LEVEL_W-1:0]         rsp_quality_level;
   logic [fttg_pkg::TIER_W-1:0]          rsp_tier_index;
   logic [fttg_pkg::STAMP_W-1:0]         rsp_avg_period_us;
   logic signed [fttg_pkg::STAMP_W-1:0]  rsp_error_us;
   logic                                 csr_valid        = 1'b0;
   logic                                 csr_ready;
   logic [fttg_pkg::CSR_IDX_W-1:0]       csr_index        = '0;
   logic [fttg_pkg::CSR_DATA_W-1:0]      csr_data         = '0;

   frame_time_quality_governor DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_timestamp_us  (req_timestamp_us),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_quality_level (rsp_quality_level),
      .rsp_tier_index    (rsp_tier_index),
      .rsp_avg_period_us (rsp_avg_period_us),
      .rsp_error_us      (rsp_error_us),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Register copy, reset values
   fttg_pkg::cfg_type reg_copy = '{target: 20'd11111, fpu: 8'd1, tol: '0, mode: '0,
                                   lmin: '0, lmax: 16'hFFFF, gain: 24'd65536};

   // Governor state copy
   logic [fttg_pkg::FPU_W-1:0]   frame_cnt  = '0;
   logic [fttg_pkg::STAMP_W-1:0] stamp_prev = '0;
   logic [fttg_pkg::LEVEL_W-1:0] lvl_now    = '0;
   logic [fttg_pkg::TIER_W-1:0]  tier_now   = '0;

   logic [fttg_pkg::STAMP_W-1:0] frame_q[$];
   gov_update_type               update_q[$];
   logic [fttg_pkg::STAMP_W-1:0] stamp_now = '0;

   int  n_queued   = 0;
   int  n_accepted = 0;
   int  n_errors   = 0;
   int  n_cycles   = 0;
   int  send_wait  = 0;
   int  stall_left = 0;
   bit  send_idle  = 1'b0;
   bit  recv_idle  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (n_errors < PRINT_CAP)
         $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      n_errors++;
   endtask

   // Mostly short gaps, now and then a long one
   function automatic int draw_gap(input bit on);
      int r;
      r = $urandom_range(0, 99);
      if (!on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Frame event: count the window, and on its last frame work out the update
   task automatic govern_frame(input logic [fttg_pkg::STAMP_W-1:0] stamp);
      logic [fttg_pkg::FPU_W-1:0]   cnt;
      logic [fttg_pkg::STAMP_W-1:0] divisor;
      logic [fttg_pkg::STAMP_W-1:0] avg;
      longint                       err;
      longint                       num;
      longint                       q;
      int                           t;
      gov_update_type               u;
      cnt = frame_cnt + 1'b1;
      if (cnt < reg_copy.fpu) begin
         frame_cnt = cnt;
         return;
      end
      frame_cnt = '0;
      divisor = (reg_copy.fpu == 0) ? fttg_pkg::STAMP_W'(1) : fttg_pkg::STAMP_W'(reg_copy.fpu);
      avg = (stamp - stamp_prev) / divisor;
      stamp_prev = stamp;

      // period error with saturation and dead zone
      err = 0;
      if (reg_copy.mode[fttg_pkg::MODE_AUTO]) begin
         err = longint'({1'b0, avg}) - longint'({1'b0, reg_copy.target});
         if (err > 64'sd2147483647) err = 64'sd2147483647;
         if (err >= 0 && err <= longint'({1'b0, reg_copy.tol})) err = 0;
      end

      // proportional step, floor of Q16, then clamp with the lower bound first
      if (reg_copy.mode[fttg_pkg::MODE_AUTO] && reg_copy.mode[fttg_pkg::MODE_LEVEL]) begin
         num = longint'({1'b0, lvl_now}) * 65536 - err * longint'({1'b0, reg_copy.gain});
         q = num >>> fttg_pkg::FRAC_W;
         if (q < longint'({1'b0, reg_copy.lmin})) q = longint'({1'b0, reg_copy.lmin});
         else if (q > longint'({1'b0, reg_copy.lmax})) q = longint'({1'b0, reg_copy.lmax});
         lvl_now = q[fttg_pkg::LEVEL_W-1:0];
      end else begin
         lvl_now = reg_copy.lmax;
      end

      // tier: up at the floor with positive error, then down at the ceiling
      if (reg_copy.mode[fttg_pkg::MODE_AUTO] && reg_copy.mode[fttg_pkg::MODE_TIER]) begin
         t = int'(tier_now);
         if (lvl_now <= reg_copy.lmin && err > 0) begin
            t = t + 1;
            if (t > fttg_pkg::TIER_COUNT - 1) t = fttg_pkg::TIER_COUNT - 1;
         end
         if (lvl_now >= reg_copy.lmax && err <= 0) begin
            t = t - 1;
            if (t < 0) t = 0;
         end
         tier_now = fttg_pkg::TIER_W'(t);
      end

      u.level = lvl_now;
      u.tier  = tier_now;
      u.avg   = avg;
      u.err   = err[fttg_pkg::STAMP_W-1:0];
      update_q.push_back(u);
   endtask

   // Frame driver
   always @(posedge clock) begin
      bit fire;
      fire = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            govern_frame(req_timestamp_us);
            n_accepted++;
         end
         if (!req_valid || fire) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (frame_q.size() > 0) begin
               req_valid        <= 1'b1;
               req_timestamp_us <= frame_q.pop_front();
               send_wait = draw_gap(send_idle);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Update monitor and stall generator
   always @(posedge clock) begin
      gov_update_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (update_q.size() == 0) begin
               report_mismatch("beat with nothing expected", rsp_avg_period_us, 0);
            end else begin
               want = update_q.pop_front();
               if (rsp_quality_level !== want.level)
                  report_mismatch("quality_level", rsp_quality_level, want.level);
               if (rsp_tier_index !== want.tier)
                  report_mismatch("tier_index", rsp_tier_index, want.tier);
               if (rsp_avg_period_us !== want.avg)
                  report_mismatch("avg_period_us", rsp_avg_period_us, want.avg);
               if (rsp_error_us !== want.err)
                  report_mismatch("error_us", rsp_error_us, want.err);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = ($urandom_range(0, 3) == 0) ? draw_gap(recv_idle) : 0;
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("tb_frame_time_quality_governor: done, errors");
         $finish;
      end
   end

   task automatic program_reg(input fttg_pkg::csr_idx_type idx, input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= fttg_pkg::CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         fttg_pkg::CSR_TARGET: reg_copy.target = fttg_pkg::TARGET_W'(value);
         fttg_pkg::CSR_FPU:    reg_copy.fpu    = fttg_pkg::FPU_W'(value);
         fttg_pkg::CSR_TOL:    reg_copy.tol    = fttg_pkg::TOL_W'(value);
         fttg_pkg::CSR_MODE:   reg_copy.mode   = fttg_pkg::MODE_W'(value);
         fttg_pkg::CSR_LMIN:   reg_copy.lmin   = fttg_pkg::LEVEL_W'(value);
         fttg_pkg::CSR_LMAX:   reg_copy.lmax   = fttg_pkg::LEVEL_W'(value);
         fttg_pkg::CSR_GAIN:   reg_copy.gain   = fttg_pkg::GAIN_W'(value);
         default: ;
      endcase
   endtask

   task automatic program_all(input int unsigned tgt, input int unsigned fpu,
                              input int unsigned tol, input int unsigned mode,
                              input int unsigned lmin, input int unsigned lmax,
                              input int unsigned gain);
      program_reg(fttg_pkg::CSR_TARGET, tgt);
      program_reg(fttg_pkg::CSR_FPU, fpu);
      program_reg(fttg_pkg::CSR_TOL, tol);
      program_reg(fttg_pkg::CSR_MODE, mode);
      program_reg(fttg_pkg::CSR_LMIN, lmin);
      program_reg(fttg_pkg::CSR_LMAX, lmax);
      program_reg(fttg_pkg::CSR_GAIN, gain);
   endtask

   task automatic queue_stamp(input logic [fttg_pkg::STAMP_W-1:0] stamp);
      stamp_now = stamp;
      frame_q.push_back(stamp);
      n_queued++;
   endtask

   task automatic queue_step(input longint step);
      queue_stamp(stamp_now + step[fttg_pkg::STAMP_W-1:0]);
   endtask

   // Frame spacing around the target, with dead-zone hits, outliers and jumps
   task automatic queue_random_frame(input int unsigned tgt, input int unsigned tol);
      int     r;
      int     spread;
      longint step;
      r = $urandom_range(0, 99);
      spread = int'(tgt / 8 + tol + 4);
      if (r < 65)
         step = longint'(tgt) + longint'($urandom_range(0, 2 * spread)) - spread;
      else if (r < 80)
         step = longint'(tgt) + longint'($urandom_range(0, tol));
      else if (r < 95)
         step = longint'($urandom_range(0, 4 * tgt + 1000));
      else begin
         queue_stamp($urandom());
         return;
      end
      if (step < 0) step = 0;
      queue_step(step);
   endtask

   // Drain: all frames taken, all updates seen, then let trailing frames finish
   task automatic settle();
      int waited;
      waited = 0;
      while (n_accepted != n_queued) @(posedge clock);
      while (update_q.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (update_q.size() > 0) begin
         report_mismatch("updates never delivered", 0, update_q.size());
         update_q.delete();
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned tgt, fpu, tol, mode, lmin, lmax, gain, a, b;
      int          n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: first window from time zero, full-range stamps, wrap
      send_idle = 1'b1;
      recv_idle = 1'b1;
      queue_stamp('0);
      queue_stamp('1);
      queue_stamp(32'd5);
      settle();

      // max gain: floor clamp, dead-zone edge, tier up to saturation and back down
      program_all(11111, 1, 100, 7, 100, 60000, 24'hFFFFFF);
      queue_step(11111);
      queue_step(11211);
      repeat (4) queue_step(11212);
      repeat (4) queue_step(1);
      settle();

      // inverted bounds, zero target, zero divisor
      program_all(0, 0, 0, 7, 5000, 1000, 65536);
      queue_step(0);
      queue_step(7);
      queue_step(300);
      settle();

      // auto without level control, largest target, zero gain
      program_all(1000000, 2, 0, 1, 0, 65535, 0);
      queue_step(5);
      queue_step(5);
      settle();
      program_all(20'hFFFFF, 1, 65535, 5, 65535, 0, 1);
      queue_step(3);
      queue_step(20'hFFFFF + 70000);
      settle();

      // random phases
      for (int p = 0; n_queued < ITEMS_TOTAL; p++) begin
         case ($urandom_range(0, 7))
            0: tgt = 0;
            1: tgt = 1;
            2: tgt = 1000000;
            3: tgt = 20'hFFFFF;
            default: tgt = $urandom_range(500, 40000);
         endcase
         if (p == 2) fpu = 255;
         else begin
            case ($urandom_range(0, 9))
               0: fpu = 0;
               1, 2, 3: fpu = $urandom_range(1, 4);
               4: fpu = $urandom_range(5, 16);
               5: fpu = $urandom_range(17, 40);
               default: fpu = $urandom_range(1, 3);
            endcase
         end
         case ($urandom_range(0, 5))
            0: tol = 0;
            1: tol = 65535;
            default: tol = $urandom_range(0, 2000);
         endcase
         mode = ($urandom_range(0, 2) != 0) ? 7 : $urandom_range(0, 7);
         case ($urandom_range(0, 5))
            0: begin
               lmin = 0;
               lmax = 65535;
            end
            1: begin
               lmin = $urandom_range(1000, 65535);
               lmax = $urandom_range(0, lmin - 1);
            end
            2: begin
               lmin = $urandom_range(0, 65535);
               lmax = lmin;
            end
            default: begin
               a = $urandom_range(0, 65535);
               b = $urandom_range(0, 65535);
               lmin = (a < b) ? a : b;
               lmax = (a < b) ? b : a;
            end
         endcase
         case ($urandom_range(0, 5))
            0: gain = 0;
            1: gain = 24'hFFFFFF;
            2: gain = 65536;
            default: gain = $urandom_range(256, 1 << 20);
         endcase
         program_all(tgt, fpu, tol, mode, lmin, lmax, gain);
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         n = (p == 2) ? 520 : 120;
         for (int i = 0; i < n; i++) queue_random_frame(tgt, tol);
         settle();
      end

      if (n_errors == 0) begin
         $display("tb_frame_time_quality_governor: done, clean");
      end else begin
         $display("tb_frame_time_quality_governor: done, errors");
      end
      $finish;
   end

endmodule
